>>> hdl/pve_pkg.sv
// ----------------------------------------------------------------------------
// pve_pkg
// Types, constants and float helper functions shared by the encoder stages.
// ----------------------------------------------------------------------------
package pve_pkg;

    // |x| < 1e-4f, compared on the magnitude bits of the pattern
    localparam logic [30:0] SMALL_MAG = 31'h38D1B717;

    // x*x rounded, scaled by 2^48, must lie strictly inside 1 +/- 1e-5f
    localparam logic [49:0] SQ_ONE = 50'h1_0000_0000_0000;
    localparam logic [49:0] SQ_TOL = 50'h0_0000_A7C5_AC00;
    localparam logic [49:0] SQ_LO  = SQ_ONE - SQ_TOL;
    localparam logic [49:0] SQ_HI  = SQ_ONE + SQ_TOL;

    // Largest exact |b-a| that still rounds below 1e-4f, on a 2^-40 grid
    localparam logic signed [52:0] DIFF_LIM = 53'sh68DB8B4;

    // Exponent field bounds of the difference test
    localparam logic [7:0] EXP_GRID = 8'd110;  // grid lsb 2^-40
    localparam logic [7:0] EXP_TINY = 8'd112;  // both below: |b-a| < 2^-14
    localparam logic [7:0] EXP_HUGE = 8'd138;  // any nonzero step is above the limit
    localparam logic [7:0] EXP_MAX  = 8'd255;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;

    typedef struct packed {
        logic [51:0] fl;    // floor of value on the 2^-40 grid, two's complement
        logic        stk;   // bits below the grid were dropped
    } grid_t;

    typedef struct packed {
        logic [2:0][47:0] prod;
        logic [2:0][7:0]  expo;
        logic [2:0]       sign;
        logic [2:0]       tiny;
        logic [2:0][15:0] word;
        logic [2:0][51:0] fl;
        logic [2:0]       stk;
        logic [1:0]       pre_dec;  // difference test settled early
        logic [1:0]       pre_val;
    } s1_t;

    typedef struct packed {
        logic [2:0][1:0]  cls;
        logic [2:0][15:0] word;
        logic [1:0][52:0] kdiff;
        logic             stk_a;
        logic [1:0]       stk_x;
        logic [1:0]       pre_dec;
        logic [1:0]       pre_val;
    } s2_t;

    typedef struct packed {
        logic [6:0]       tag;
        logic [2:0][15:0] word;
        logic [2:0]       mask;
    } s3_t;

    function automatic logic [15:0] pack_word(input logic [31:0] p);
        logic signed [9:0] s;
        logic signed [9:0] d;
        logic signed [9:0] sh;
        logic [31:0]       v;
        logic [9:0]        m;
        s = $signed({2'b00, p[30:23]}) - 10'sd128;
        if (s < -10'sd16)
            d = -10'sd16;
        else if (s > 10'sd15)
            d = 10'sd15;
        else
            d = s;
        v = {13'd0, p[31:13]};
        if (s < -10'sd16)
        begin
            sh = d - s;
            if (sh >= 10'sd10)
                m = '1;
            else
                m = 10'((v << sh[3:0]) | ((32'd1 << sh[3:0]) - 32'd1));
        end
        else if (s > 10'sd15)
        begin
            sh = s - d;
            if (sh >= 10'sd32)
                m = '0;
            else
                m = 10'(v >> sh[4:0]);
        end
        else
        begin
            sh = 10'sd0;
            m  = v[9:0];
        end
        return {p[31], 5'(d + 10'sd16), m};
    endfunction

    function automatic grid_t to_grid(input logic [31:0] p);
        logic [7:0]  ee;
        logic [23:0] mant;
        logic [7:0]  rs;
        logic [50:0] mag;
        logic [51:0] ext;
        grid_t       g;
        ee   = (p[30:23] == 8'd0) ? 8'd1 : p[30:23];
        mant = {(p[30:23] != 8'd0), p[22:0]};
        if (ee >= EXP_GRID)
        begin
            rs    = ee - EXP_GRID;
            mag   = 51'(mant) << rs;
            g.stk = 1'b0;
        end
        else
        begin
            rs    = EXP_GRID - ee;
            mag   = 51'(mant >> rs);
            g.stk = ((mant >> rs) << rs) != mant;
        end
        ext = {1'b0, mag};
        if (!p[31])
            g.fl = ext;
        else if (g.stk)
            g.fl = ~ext;
        else
            g.fl = ~ext + 52'd1;
        return g;
    endfunction

    // Difference test decided without the grid: non-finite, large or tiny
    function automatic logic [1:0] pair_pre(input logic [31:0] pa, input logic [31:0] px);
        logic [7:0] ea;
        logic [7:0] ex;
        logic [1:0] r;
        ea = pa[30:23];
        ex = px[30:23];
        if (ea == EXP_MAX || ex == EXP_MAX)
            r = 2'b10;
        else if (ea >= EXP_HUGE || ex >= EXP_HUGE)
            r = {1'b1, pa == px};
        else if (ea < EXP_TINY && ex < EXP_TINY)
            r = 2'b11;
        else
            r = 2'b00;
        return r;
    endfunction

    // Rounded square within 1 +/- 1e-5f; only exponents 126 and 127 can hit
    function automatic logic sq_near(input logic [7:0] e, input logic [47:0] pr);
        logic        rnd;
        logic [24:0] r;
        logic [49:0] sc;
        logic        hit;
        hit = 1'b0;
        rnd = 1'b0;
        r   = '0;
        sc  = '0;
        if (e == 8'd127 && !pr[47])
        begin
            rnd = pr[22] && ((|pr[21:0]) || pr[23]);
            r   = 25'(pr[46:23]) + 25'(rnd);
            sc  = 50'(r) << 25;
            hit = (sc > SQ_LO) && (sc < SQ_HI);
        end
        else if (e == 8'd126 && pr[47])
        begin
            rnd = pr[23] && ((|pr[22:0]) || pr[24]);
            r   = 25'(pr[47:24]) + 25'(rnd);
            sc  = 50'(r) << 24;
            hit = (sc > SQ_LO) && (sc < SQ_HI);
        end
        return hit;
    endfunction

endpackage

>>> hdl/packed_vector_encoder.sv
// ----------------------------------------------------------------------------
// packed_vector_encoder
// Classifies a three-component float vector and emits a tag plus packed words.
// ----------------------------------------------------------------------------
// Each input transaction carries three single-precision bit patterns. Every
// vector leaves as one to four output transactions: a tag byte (out_kind 0)
// and then a 16-bit packed word (out_kind 1) for each component that has to
// be sent; out_last marks the final one. A transaction enters a three-stage
// pipeline (mantissa squaring and grid conversion, class and difference,
// tag and send mask) and then an output sequencer that hands out one result
// per cycle while out_stall is low. The tag passes the stage-1, stage-2 and
// stage-3 registers and then the output register before it is on the output.
// The sequencer sets the rate: a vector occupies it until all its results, one
// to four, are handed out, and the pipeline keeps taking new vectors while
// earlier ones wait at the output.
// Reset clears only the valid flags and the sequencer count.
// ----------------------------------------------------------------------------
module packed_vector_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] comp_a,
    input  logic [31:0] comp_b,
    input  logic [31:0] comp_c,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [15:0] out_value,
    output logic        out_last
);
    import pve_pkg::*;

    logic  in_ready;
    logic  s1_valid;
    logic  s1_ready;
    s1_t   s1_data;
    logic  s3_valid;
    logic  s3_ready;
    s3_t   s3_data;

    // Stage 1: 24x24 mantissa squares, fixed-point grid values, packed words
    pve_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .comp_a   (comp_a),
        .comp_b   (comp_b),
        .comp_c   (comp_c),
        .dn_ready (s1_ready),
        .dn_valid (s1_valid),
        .dn_data  (s1_data)
    );

    // Stages 2 and 3: rounded-square window, b-a / c-a limits, tag
    pve_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_ready (s3_ready),
        .dn_valid (s3_valid),
        .dn_data  (s3_data)
    );

    // Output register and per-vector result sequencing
    pve_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s3_valid),
        .up_ready  (s3_ready),
        .up_data   (s3_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_last  (out_last)
    );

    assign in_stall = !in_ready;

endmodule

>>> hdl/pve_prep.sv
// ----------------------------------------------------------------------------
// pve_prep
// First stage: squares of the mantissas, grid conversion, packed words.
// ----------------------------------------------------------------------------
module pve_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        comp_a,
    input  logic [31:0]        comp_b,
    input  logic [31:0]        comp_c,
    input  logic               dn_ready,
    output logic               dn_valid,
    output pve_pkg::s1_t       dn_data
);
    import pve_pkg::*;

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic [2:0][31:0] pat;
    grid_t       g [3];
    logic [1:0]  pre_b;
    logic [1:0]  pre_c;

    assign pat = {comp_c, comp_b, comp_a};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g[i] = to_grid(pat[i]);
            data_next.prod[i]  = 48'({(pat[i][30:23] != 8'd0), pat[i][22:0]})
                               * 48'({(pat[i][30:23] != 8'd0), pat[i][22:0]});
            data_next.expo[i]  = pat[i][30:23];
            data_next.sign[i]  = pat[i][31];
            data_next.tiny[i]  = pat[i][30:0] < SMALL_MAG;
            data_next.word[i]  = pack_word(pat[i]);
            data_next.fl[i]    = g[i].fl;
            data_next.stk[i]   = g[i].stk;
        end
        pre_b = pair_pre(comp_a, comp_b);
        pre_c = pair_pre(comp_a, comp_c);
        data_next.pre_dec = {pre_c[1], pre_b[1]};
        data_next.pre_val = {pre_c[0], pre_b[0]};
    end

    assign in_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> hdl/pve_eval.sv
// ----------------------------------------------------------------------------
// pve_eval
// Second and third stages: classes and grid differences, then tag and mask.
// ----------------------------------------------------------------------------
module pve_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  pve_pkg::s1_t       up_data,
    input  logic               dn_ready,
    output logic               dn_valid,
    output pve_pkg::s3_t       dn_data
);
    import pve_pkg::*;

    logic  v2_reg;
    logic  v3_reg;
    logic  r2;
    logic  r3;
    s2_t   s2_reg;
    s2_t   s2_next;
    s3_t   s3_reg;
    s3_t   s3_next;
    logic signed [52:0] lo;
    logic signed [52:0] hi;
    logic [1:0] close;
    logic       flag;

    // stage 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (up_data.tiny[i])
                s2_next.cls[i] = CLS_ZERO;
            else if (sq_near(up_data.expo[i], up_data.prod[i]))
                s2_next.cls[i] = {1'b1, up_data.sign[i]};
            else
                s2_next.cls[i] = CLS_NONE;
        end
        for (int j = 0; j < 2; j++)
        begin
            s2_next.kdiff[j] = {up_data.fl[j + 1][51], up_data.fl[j + 1]}
                             - {up_data.fl[0][51], up_data.fl[0]};
            s2_next.stk_x[j] = up_data.stk[j + 1];
        end
        s2_next.word    = up_data.word;
        s2_next.stk_a   = up_data.stk[0];
        s2_next.pre_dec = up_data.pre_dec;
        s2_next.pre_val = up_data.pre_val;
    end

    // stage 3: exact |x-a| against the rounding limit, sticky side decides
    always_comb
    begin
        lo = 53'sd0;
        hi = 53'sd0;
        for (int j = 0; j < 2; j++)
        begin
            lo = s2_reg.stk_a    ? (53'sd1 - DIFF_LIM) : (53'sd0 - DIFF_LIM);
            hi = s2_reg.stk_x[j] ? (DIFF_LIM - 53'sd1) : DIFF_LIM;
            if (s2_reg.pre_dec[j])
                close[j] = s2_reg.pre_val[j];
            else
                close[j] = ($signed(s2_reg.kdiff[j]) >= lo)
                        && ($signed(s2_reg.kdiff[j]) <= hi);
        end
        flag            = &close;
        s3_next.tag     = {flag, s2_reg.cls[2], s2_reg.cls[1], s2_reg.cls[0]};
        s3_next.word    = s2_reg.word;
        s3_next.mask[0] = s2_reg.cls[0] == CLS_NONE;
        s3_next.mask[1] = !flag && s2_reg.cls[1] == CLS_NONE;
        s3_next.mask[2] = !flag && s2_reg.cls[2] == CLS_NONE;
    end

    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign up_ready = r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r2)
                v2_reg <= up_valid;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2 && up_valid)
            s2_reg <= s2_next;
        if (r3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign dn_valid = v3_reg;
    assign dn_data  = s3_reg;

endmodule

>>> hdl/pve_emit.sv
// ----------------------------------------------------------------------------
// pve_emit
// Output register and sequencer: tag byte, then the selected packed words.
// ----------------------------------------------------------------------------
module pve_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  pve_pkg::s3_t       up_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_kind,
    output logic [15:0]        out_value,
    output logic               out_last
);
    import pve_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic             kind_reg;
    logic             kind_next;
    logic [15:0]      value_reg;
    logic [15:0]      value_next;
    logic             last_reg;
    logic             last_next;
    logic [2:0]       rem_reg;
    logic [2:0]       rem_next;
    logic [2:0][15:0] word_reg;
    logic             advance;
    logic             load;

    assign advance  = !valid_reg || !out_stall;
    assign up_ready = advance && (rem_reg == 3'd0);
    assign load     = up_ready && up_valid;

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        if (advance)
        begin
            if (rem_reg != 3'd0)
            begin
                rem_next   = rem_reg & (rem_reg - 3'd1);
                valid_next = 1'b1;
                kind_next  = 1'b1;
                last_next  = rem_next == 3'd0;
                if (rem_reg[0])
                    value_next = word_reg[0];
                else if (rem_reg[1])
                    value_next = word_reg[1];
                else
                    value_next = word_reg[2];
            end
            else if (up_valid)
            begin
                rem_next   = up_data.mask;
                valid_next = 1'b1;
                kind_next  = 1'b0;
                last_next  = up_data.mask == 3'd0;
                value_next = {9'd0, up_data.tag};
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        if (load)
            word_reg <= up_data.word;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/pve_checker.sv
// ----------------------------------------------------------------------------
// pve_checker
// Port-level checks on the result stream of the encoder.
// ----------------------------------------------------------------------------
module pve_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        out_kind,
    input logic [15:0] out_value,
    input logic        out_last
);
    logic expect_tag_reg;

    // a new vector always opens with its tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expect_tag_reg <= 1'b1;
        else if (out_valid && !out_stall)
            expect_tag_reg <= out_last;
    end

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == !expect_tag_reg))
        else $error("result kind out of order");

    a_tag_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind |-> out_value[15:7] == 9'd0)
        else $error("tag has upper bits set");

    a_tag_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind && out_last |->
            out_value[1:0] != 2'd0
            && (out_value[6] || (out_value[3:2] != 2'd0 && out_value[5:4] != 2'd0)))
        else $error("tag ends a vector that still needs words");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind packed_vector_encoder pve_checker u_pve_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
);
